// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the edit distance core.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property on the rising clock, disabled while reset is low
`define OSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Same-cycle implication: whenever cond holds, expr must hold too
`define OSA_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    `OSA_ASSERT(label, clk, rst_n, (cond) |-> (expr))
`else
`define OSA_ASSERT(label, clk, rst_n, prop)
`define OSA_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== src/osa_pkg.sv =====
// Package for the optimal string alignment distance core: sizes, action codes,
// FSM states, the cell link struct and the output saturation function.
`default_nettype none

package osa_pkg;

    // Store depth and symbol width
    localparam int MAX_LEN     = 64;
    localparam int SYMBOL_BITS = 8;

    // Port widths fixed by the interface
    localparam int ACT_W = 2;
    localparam int SYM_IN_W = 8;
    localparam int OUT_W = 7;
    localparam int OUT_MAX = (1 << OUT_W) - 1;

    // Derived widths
    localparam int SYM_W  = SYMBOL_BITS;
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int DIST_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = (DIST_W > OUT_W) ? DIST_W : OUT_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SRC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TGT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIN = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // What one cell hands to its right-hand neighbour each cycle
    typedef struct packed {
        logic              vld;     // a row was computed last cycle
        logic              last;    // that row was the final source row
        logic              tr_ok;   // row index above one
        logic [SYM_W-1:0]  a;       // source symbol of that row
        logic [SYM_W-1:0]  a_prev;  // source symbol of the row before
        logic [SYM_W-1:0]  b;       // target symbol held by the cell
        logic [DIST_W-1:0] cur;     // D[i][j]
        logic [DIST_W-1:0] old;     // D[i-1][j]
        logic [DIST_W-1:0] dg2;     // D[i-2][j-1]
    } t_link;

    // Clamp a distance to the output field
    function automatic logic [OUT_W-1:0] sat_dist(input logic [DIST_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        return (wide > CMP_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(wide);
    endfunction

endpackage

`default_nettype wire

// ===== src/osa_edit_distance_core.sv =====
// Optimal string alignment (restricted Damerau-Levenshtein) distance core.
// Top level: load store, source RAM, row feed, cell chain and result register.
// Depends on osa_pkg, osa_ram, osa_cell and assert_macros.svh.
//
// Each append beat (source or target) is taken while the core is idle. A finish
// beat starts a wavefront through a row of MAX_LEN cells, one cell per target
// symbol; the source symbols stream out of a RAM one per cycle into the chain,
// and the result is registered from the last target cell, or from the lengths
// when either string is empty. The input is stalled while a finish is being
// worked on; appends are still taken while an earlier result waits at the
// output. Action 3 is taken and ignored.
`default_nettype none

module osa_edit_distance_core
    import osa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [SYM_IN_W-1:0] i_symbol,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [OUT_W-1:0]         o_distance,
    output logic                     o_overflow
);

`include "assert_macros.svh"

    t_state            r_state;
    t_state            n_state;

    logic [DIST_W-1:0] r_src_len;
    logic [DIST_W-1:0] r_tgt_len;
    logic              r_ovf;
    logic [DIST_W-1:0] r_n;
    logic [DIST_W-1:0] r_m;
    logic [DIST_W-1:0] r_res;
    logic              r_res_ovf;
    logic              r_out_vld;
    logic [OUT_W-1:0]  r_out_dist;
    logic              r_out_ovf;

    logic              r_issue;
    logic [IDX_W-1:0]  r_rd_addr;
    logic              r_q_vld;
    logic              r_q_last;
    logic [DIST_W-1:0] r_q_row;
    logic              r_hd_vld;
    logic              r_hd_last;
    logic              r_hd_tr_ok;
    logic [SYM_W-1:0]  r_hd_a;
    logic [SYM_W-1:0]  r_hd_a_prev;
    logic [DIST_W-1:0] r_hd_cur;
    logic [DIST_W-1:0] r_hd_old;

    logic              in_acc;
    logic              fin_acc;
    logic              start_run;
    logic              run_done;
    logic              load_out;
    logic              src_wr;
    logic              tgt_wr;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  ram_q;
    logic [DIST_W-1:0] n_minus;
    logic [IDX_W-1:0]  last_addr;
    logic [DIST_W-1:0] m_minus;
    logic [IDX_W-1:0]  sel_idx;

    t_link             hd_link;
    t_link             links [MAX_LEN];
    t_link             sel;

    // Input decode
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign sym        = i_symbol[SYM_W-1:0];
    assign src_wr     = in_acc && (i_action == ACT_SRC) && (r_src_len < DIST_W'(MAX_LEN));
    assign tgt_wr     = in_acc && (i_action == ACT_TGT) && (r_tgt_len < DIST_W'(MAX_LEN));
    assign n_minus    = r_n - DIST_W'(1);
    assign last_addr  = n_minus[IDX_W-1:0];
    assign m_minus    = r_m - DIST_W'(1);
    assign sel_idx    = m_minus[IDX_W-1:0];
    assign sel        = links[sel_idx];

    // FSM state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // FSM next state and strobes
    always_comb begin
        n_state   = r_state;
        fin_acc   = 1'b0;
        start_run = 1'b0;
        run_done  = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_action == ACT_FIN)) begin
                    fin_acc = 1'b1;
                    if ((r_src_len == '0) || (r_tgt_len == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        start_run = 1'b1;
                        n_state   = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (sel.vld && sel.last) begin
                    run_done = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: lengths, overflow flag, feed and output valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= '0;
            r_tgt_len <= '0;
            r_ovf     <= 1'b0;
            r_issue   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_hd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (fin_acc) begin
                r_src_len <= '0;
                r_tgt_len <= '0;
                r_ovf     <= 1'b0;
            end else begin
                if (src_wr) begin
                    r_src_len <= r_src_len + DIST_W'(1);
                end
                if (tgt_wr) begin
                    r_tgt_len <= r_tgt_len + DIST_W'(1);
                end
                if (in_acc && ((i_action == ACT_SRC) || (i_action == ACT_TGT))
                    && !src_wr && !tgt_wr) begin
                    r_ovf <= 1'b1;
                end
            end

            if (start_run) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_rd_addr == last_addr)) begin
                r_issue <= 1'b0;
            end
            r_q_vld  <= r_issue && !start_run;
            r_hd_vld <= r_q_vld && !start_run;

            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: captured lengths, row feed, result
    always_ff @(posedge i_clk) begin
        if (fin_acc) begin
            r_n       <= r_src_len;
            r_m       <= r_tgt_len;
            r_res_ovf <= r_ovf;
            r_res     <= r_src_len | r_tgt_len;
        end else if (run_done) begin
            r_res <= sel.cur;
        end

        if (start_run) begin
            r_rd_addr <= '0;
        end else if (r_issue) begin
            r_rd_addr <= r_rd_addr + IDX_W'(1);
        end
        r_q_last <= (r_rd_addr == last_addr);
        r_q_row  <= DIST_W'(r_rd_addr) + DIST_W'(1);

        if (r_q_vld) begin
            r_hd_a      <= ram_q;
            r_hd_a_prev <= r_hd_a;
            r_hd_cur    <= r_q_row;
            r_hd_old    <= r_q_row - DIST_W'(1);
            r_hd_tr_ok  <= (r_q_row != DIST_W'(1));
            r_hd_last   <= r_q_last;
        end

        if (load_out) begin
            r_out_dist <= sat_dist(r_res);
            r_out_ovf  <= r_res_ovf;
        end
    end

    // Source symbol store
    osa_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_wr),
        .i_waddr (r_src_len[IDX_W-1:0]),
        .i_wdata (sym),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_q)
    );

    // Column zero of the table, fed into the first cell
    always_comb begin
        hd_link.vld    = r_hd_vld;
        hd_link.last   = r_hd_last;
        hd_link.tr_ok  = r_hd_tr_ok;
        hd_link.a      = r_hd_a;
        hd_link.a_prev = r_hd_a_prev;
        hd_link.b      = '0;
        hd_link.cur    = r_hd_cur;
        hd_link.old    = r_hd_old;
        hd_link.dg2    = '0;
    end

    // Cell chain, one cell per target position
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        logic load_b;
        assign load_b = tgt_wr && (r_tgt_len == DIST_W'(k));
        osa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (start_run),
            .i_col    (DIST_W'(k + 1)),
            .i_load_b (load_b),
            .i_symbol (sym),
            .i_nb     ((k == 0) ? hd_link : links[(k == 0) ? 0 : k - 1]),
            .o_link   (links[k])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_distance  = r_out_dist;
    assign o_overflow  = r_out_ovf;

    // Checks
    `OSA_ASSERT_IMPL(a_len_cap, i_clk, i_rst_n, 1'b1, (r_src_len <= DIST_W'(MAX_LEN)) && (r_tgt_len <= DIST_W'(MAX_LEN)))
    `OSA_ASSERT_IMPL(a_run_bound, i_clk, i_rst_n, run_done, ({1'b0, sel.cur} <= ({1'b0, r_n} + {1'b0, r_m})))
    `OSA_ASSERT_IMPL(a_feed_in_run, i_clk, i_rst_n, r_hd_vld, r_state == S_RUN)
    `OSA_ASSERT(a_run_exit, i_clk, i_rst_n, (r_state == S_RUN) |=> ((r_state == S_RUN) || (r_state == S_DONE)))

endmodule

`default_nettype wire

// ===== src/osa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module osa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/osa_cell.sv =====
// One column cell of the systolic edit distance row: holds a target symbol and
// computes its column of the table one row per beat. Depends on osa_pkg.
`default_nettype none

module osa_cell
    import osa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIST_W-1:0] i_col,
    input  wire logic              i_load_b,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire t_link             i_nb,
    output t_link                  o_link
);

    logic              r_vld;
    logic              r_last;
    logic              r_tr_ok;
    logic [SYM_W-1:0]  r_a;
    logic [SYM_W-1:0]  r_a_prev;
    logic [SYM_W-1:0]  r_b;
    logic [DIST_W-1:0] r_cur;
    logic [DIST_W-1:0] r_old;
    logic [DIST_W-1:0] r_dg1;
    logic [DIST_W-1:0] r_dg2;

    logic [DIST_W:0]   c_up;
    logic [DIST_W:0]   c_left;
    logic [DIST_W:0]   c_diag;
    logic [DIST_W:0]   c_swap;
    logic [DIST_W:0]   best_a;
    logic [DIST_W:0]   best_b;
    logic [DIST_W:0]   best;
    logic              swap_ok;

    // Candidate costs: deletion, insertion, substitution, transposition
    always_comb begin
        c_up    = {1'b0, r_cur} + (DIST_W+1)'(1);
        c_left  = {1'b0, i_nb.cur} + (DIST_W+1)'(1);
        c_diag  = {1'b0, i_nb.old} + (DIST_W+1)'(i_nb.a != r_b);
        c_swap  = {1'b0, i_nb.dg2} + (DIST_W+1)'(1);
        swap_ok = i_nb.tr_ok && (i_col > DIST_W'(1))
                  && (i_nb.a == i_nb.b) && (i_nb.a_prev == r_b);
        best_a  = (c_up < c_left) ? c_up : c_left;
        best_b  = (c_diag < best_a) ? c_diag : best_a;
        best    = (swap_ok && (c_swap < best_b)) ? c_swap : best_b;
    end

    // Control: the row beat is a registered copy of the neighbour's
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_start) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_nb.vld;
        end
    end

    // Column state and pass-along data
    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            r_b <= i_symbol;
        end
        if (i_start) begin
            r_cur <= i_col;
        end else if (i_nb.vld) begin
            r_cur    <= best[DIST_W-1:0];
            r_old    <= r_cur;
            r_dg1    <= i_nb.old;
            r_dg2    <= r_dg1;
            r_a      <= i_nb.a;
            r_a_prev <= i_nb.a_prev;
            r_tr_ok  <= i_nb.tr_ok;
            r_last   <= i_nb.last;
        end
    end

    always_comb begin
        o_link.vld    = r_vld;
        o_link.last   = r_last;
        o_link.tr_ok  = r_tr_ok;
        o_link.a      = r_a;
        o_link.a_prev = r_a_prev;
        o_link.b      = r_b;
        o_link.cur    = r_cur;
        o_link.old    = r_old;
        o_link.dg2    = r_dg2;
    end

endmodule

`default_nettype wire

// ===== verif/osa_checker.sv =====
// Checker for the edit distance core: watches both channels, predicts each result.
// Depends on osa_pkg for sizes, widths and action codes.
module osa_checker
    import osa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [SYM_IN_W-1:0] i_symbol,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [OUT_W-1:0]    i_distance,
    input  logic                i_overflow,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic             overflow;
    } t_osa_result;

    // Shadow copy of the two string stores
    logic [SYM_W-1:0] src_sym [MAX_LEN];
    logic [SYM_W-1:0] tgt_sym [MAX_LEN];
    int               src_len;
    int               tgt_len;
    logic             dropped_seen;

    t_osa_result      distance_q [$];
    int               err_cnt;

    // Restricted Damerau-Levenshtein over the shadow stores, two rows kept back
    function automatic int osa_distance();
        int two_back [MAX_LEN+1];
        int one_back [MAX_LEN+1];
        int row      [MAX_LEN+1];
        int best;
        int cost;
        for (int j = 0; j <= tgt_len; j++)
            one_back[j] = j;
        for (int i = 1; i <= src_len; i++) begin
            row[0] = i;
            for (int j = 1; j <= tgt_len; j++) begin
                cost = (src_sym[i-1] == tgt_sym[j-1]) ? 0 : 1;
                best = one_back[j] + 1;
                if (row[j-1] + 1 < best)
                    best = row[j-1] + 1;
                if (one_back[j-1] + cost < best)
                    best = one_back[j-1] + cost;
                // adjacent swap
                if (i > 1 && j > 1) begin
                    if (src_sym[i-1] == tgt_sym[j-2] && src_sym[i-2] == tgt_sym[j-1] &&
                        two_back[j-2] + 1 < best)
                        best = two_back[j-2] + 1;
                end
                row[j] = best;
            end
            two_back = one_back;
            one_back = row;
        end
        return one_back[tgt_len];
    endfunction

    always @(posedge i_clk) begin
        t_osa_result want;
        int          pred_dist;
        if (!i_rst_n) begin
            src_len      = 0;
            tgt_len      = 0;
            dropped_seen = 1'b0;
            err_cnt      = 0;
            distance_q.delete();
        end else begin
            // Result beat: compare with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: unexpected result beat, distance %0d overflow %0b",
                             $time, i_distance, i_overflow);
                    err_cnt++;
                end else begin
                    want = distance_q.pop_front();
                    if (i_distance !== want.distance) begin
                        $display("%0t: distance mismatch, expected %0d, got %0d",
                                 $time, want.distance, i_distance);
                        err_cnt++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %0b, got %0b",
                                 $time, want.overflow, i_overflow);
                        err_cnt++;
                    end
                end
            end
            // Input beat: update the shadow stores, predict on finish
            if (i_in_valid && !i_in_stall) begin
                case (i_action)
                    ACT_SRC: begin
                        if (src_len < MAX_LEN) begin
                            src_sym[src_len] = i_symbol[SYM_W-1:0];
                            src_len++;
                        end else begin
                            dropped_seen = 1'b1;
                        end
                    end
                    ACT_TGT: begin
                        if (tgt_len < MAX_LEN) begin
                            tgt_sym[tgt_len] = i_symbol[SYM_W-1:0];
                            tgt_len++;
                        end else begin
                            dropped_seen = 1'b1;
                        end
                    end
                    ACT_FIN: begin
                        pred_dist = osa_distance();
                        if (pred_dist > OUT_MAX)
                            pred_dist = OUT_MAX;
                        want.distance = OUT_W'(pred_dist);
                        want.overflow = dropped_seen;
                        distance_q.push_back(want);
                        src_len      = 0;
                        tgt_len      = 0;
                        dropped_seen = 1'b0;
                    end
                    default: ;  // unused action, no effect
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= distance_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the edit distance core testbench: clock, reset, string stimulus and verdict.
// Depends on osa_pkg, osa_edit_distance_core and osa_checker.
module tb_top;
    import osa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
    localparam int ITEM_TARGET = 950;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                i_out_stall;
    logic [ACT_W-1:0]    i_action;
    logic [SYM_IN_W-1:0] i_symbol;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [OUT_W-1:0]    o_distance;
    logic                o_overflow;
    int                  fail_count;
    int                  results_pending;

    // Idle rates in percent, changed per phase
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int                  beats_sent;

    // Strings for the next comparison
    logic [7:0]          src_q [$];
    logic [7:0]          tgt_q [$];
    logic                narrow_alpha;
    logic [7:0]          alpha_base;

    osa_edit_distance_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_symbol    (i_symbol),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .o_overflow  (o_overflow)
    );

    osa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_symbol    (i_symbol),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_distance  (o_distance),
        .i_overflow  (o_overflow),
        .o_errors    (fail_count),
        .o_pending   (results_pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // One input beat; returns on the falling edge after it was taken
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_symbol   <= sym;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
        if (act != ACT_NOP)
            beats_sent++;
    endtask

    // Hold the input off until every outstanding result is out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_pending != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        if (narrow_alpha)
            return alpha_base + 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // Load both strings in a random interleave, odd ignored beats, then finish
    task automatic play_pair();
        while (src_q.size() != 0 || tgt_q.size() != 0) begin
            if ($urandom_range(19) == 0)
                send_beat(ACT_NOP, 8'($urandom_range(255)));
            if (tgt_q.size() == 0 || (src_q.size() != 0 && $urandom_range(1) == 1))
                send_beat(ACT_SRC, src_q.pop_front());
            else
                send_beat(ACT_TGT, tgt_q.pop_front());
        end
        send_beat(ACT_FIN, 8'($urandom_range(255)));
    endtask

    // Source string, and a target that is mostly a lightly edited copy
    task automatic build_pair();
        int          len;
        int          pos;
        logic        long_run;
        logic [7:0]  held;
        long_run     = ($urandom_range(99) < 4);
        narrow_alpha = 1'($urandom_range(1));
        alpha_base   = 8'($urandom_range(255));
        len = long_run ? $urandom_range(60, 70) : $urandom_range(0, 8);
        src_q.delete();
        tgt_q.delete();
        repeat (len)
            src_q.push_back(pick_symbol());
        if ($urandom_range(3) == 0) begin
            len = long_run ? $urandom_range(60, 70) : $urandom_range(0, 8);
            repeat (len)
                tgt_q.push_back(pick_symbol());
        end else begin
            tgt_q = src_q;
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(3))
                    0: if (tgt_q.size() != 0) begin
                        tgt_q[$urandom_range(tgt_q.size() - 1)] = pick_symbol();
                    end
                    1: if (tgt_q.size() != 0) begin
                        tgt_q.delete($urandom_range(tgt_q.size() - 1));
                    end
                    2: tgt_q.insert($urandom_range(tgt_q.size()), pick_symbol());
                    default: if (tgt_q.size() >= 2) begin
                        pos          = $urandom_range(tgt_q.size() - 2);
                        held         = tgt_q[pos];
                        tgt_q[pos]   = tgt_q[pos+1];
                        tgt_q[pos+1] = held;
                    end
                endcase
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_SRC;
        i_symbol       = 8'h00;
        i_out_stall    = 1'b0;
        send_idle_pct  = 20;
        recv_stall_pct = 49;
        beats_sent     = 0;
        phase          = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: both empty, one side empty, swap, extreme symbols, ignored action
        src_q = {};             tgt_q = {};             play_pair();
        src_q = {8'h00};        tgt_q = {};             play_pair();
        src_q = {};             tgt_q = {8'hff, 8'h80}; play_pair();
        src_q = {8'h00, 8'hff}; tgt_q = {8'hff, 8'h00}; play_pair();
        src_q = {8'h5a};        tgt_q = {8'ha5};        play_pair();
        send_beat(ACT_NOP, 8'hff);
        src_q = {8'h0f};        tgt_q = {8'h0f};        play_pair();
        src_q = {8'h61, 8'h62, 8'h63}; tgt_q = {8'h63, 8'h61}; play_pair();

        // Random: mostly well-formed pairs, some stray beats
        while (beats_sent < ITEM_TARGET) begin
            if (phase == 0 && beats_sent >= ITEM_TARGET / 3) begin
                wait_drained();
                send_idle_pct  = 49;
                recv_stall_pct = 20;
                phase          = 1;
            end else if (phase == 1 && beats_sent >= 2 * ITEM_TARGET / 3) begin
                wait_drained();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                phase          = 2;
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                build_pair();
                play_pair();
            end
        end

        // Drain and settle
        i_in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
